// ===== design/bpa_pkg.sv =====
// Shared types and codes for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_ORD  = 2'd1;
   localparam logic [1:0] STATUS_NO_MEM   = 2'd2;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd3;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_INIT,
      OP_NOP,
      OP_BAD_ORDER,
      OP_BAD_ADDR
   } bpa_op_type;

   typedef struct packed {
      bpa_op_type  op;
      logic [3:0]  order;
      logic [10:0] page;
   } bpa_cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_POP,
      ST_SPLIT,
      ST_PUSH,
      ST_CHECK,
      ST_SCAN,
      ST_CMP,
      ST_SHRD,
      ST_SHWR,
      ST_DONE
   } bpa_state_type;

endpackage

// ===== design/bpa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bpa_front.sv =====
// Request decode and command queue ahead of the allocator engine.
`timescale 1ns / 1ps
module bpa_front import bpa_pkg::*; #(
   parameter int TOP_ORDER  = 10,
   parameter int MIN_ORDER  = 0,
   parameter int POOL_PAGES = 1024,
   parameter int SW         = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic [SW-1:0]     pool,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output bpa_cmd_type       cmd
);

   bpa_cmd_type q_ff [2];
   bpa_cmd_type q_in [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  n_ff, n_in;
   bpa_cmd_type dec;
   logic        push, pop;

   always_comb begin
      dec.order = req_tdata[3:0];
      dec.page  = req_tdata[14:4];
      if (req_tuser == FUNC_INIT) begin
         dec.op = OP_INIT;
      end else if (req_tuser != FUNC_ALLOC && req_tuser != FUNC_FREE) begin
         dec.op = OP_NOP;
      end else if (int'(dec.order) < MIN_ORDER || int'(dec.order) > TOP_ORDER) begin
         dec.op = OP_BAD_ORDER;
      end else if (req_tuser == FUNC_ALLOC) begin
         dec.op = OP_ALLOC;
      end else if (SW'(dec.page) >= pool) begin
         dec.op = OP_BAD_ADDR;
      end else begin
         dec.op = OP_FREE;
      end
   end

   assign req_tready = (n_ff != 2'd2);
   assign cmd_valid  = (n_ff != 2'd0);
   assign cmd        = q_ff[rp_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      q_in     = q_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      n_in     = n_ff;
      if (push) begin
         q_in[wp_ff] = dec;
         wp_in       = ~wp_ff;
      end
      if (pop) begin
         rp_in = ~rp_ff;
      end
      if (push && !pop) begin
         n_in = n_ff + 2'd1;
      end else if (pop && !push) begin
         n_in = n_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

endmodule

// ===== design/bpa_back.sv =====
// Allocator engine: free lists, search, split, merge and result register.
`timescale 1ns / 1ps
module bpa_back import bpa_pkg::*; #(
   parameter int TOP_ORDER  = 10,
   parameter int POOL_PAGES = 1024,
   parameter int SW         = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   output logic          cmd_ready,
   input  bpa_cmd_type   cmd,
   input  logic [SW-1:0] pool,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [9:0]    rsp_block,
   output logic [10:0]   rsp_used
);

   localparam int IW    = $clog2(POOL_PAGES);
   localparam int CW    = $clog2(POOL_PAGES + 1);
   localparam int OW    = $clog2(TOP_ORDER + 2);
   localparam int OI    = $clog2(TOP_ORDER + 1);
   localparam int XW    = (SW > TOP_ORDER + 1) ? SW : TOP_ORDER + 1;
   localparam int DEPTH = (TOP_ORDER + 1) * POOL_PAGES;
   localparam int RA    = $clog2(DEPTH);
   localparam int UW    = ((TOP_ORDER + 1 > 11) ? TOP_ORDER + 1 : 11) + 1;
   localparam logic [UW-1:0] USED_MAX = UW'(2047);

   bpa_state_type state_ff, state_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [3:0]    ord_ff, ord_in;
   logic [IW-1:0] blk_ff, blk_in;
   logic [IW-1:0] psh_ff, psh_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          alloc_ff, alloc_in;
   logic          emit_ff, emit_in;
   logic [10:0]   used_ff, used_in;
   logic [CW-1:0] cnt_ff [TOP_ORDER+1];
   logic [CW-1:0] cnt_in [TOP_ORDER+1];
   logic [1:0]    status_ff, status_in;
   logic [9:0]    blkout_ff, blkout_in;
   logic          rvalid_ff, rvalid_in;
   logic [1:0]    rstatus_ff, rstatus_in;
   logic [9:0]    rblock_ff, rblock_in;
   logic [10:0]   rused_ff, rused_in;

   logic          ram_we, ram_re;
   logic [RA-1:0] ram_wa, ram_ra;
   logic [IW-1:0] ram_wd, ram_rd;

   logic [CW-1:0] cnt_cur, idx_nxt;
   logic [OW-1:0] nc;
   logic [XW-1:0] bud, sbud;
   logic          bud_out, sbud_out;
   logic [UW-1:0] sz, used_add, used_sub;
   logic [OI-1:0] top;
   logic          top_found;

   function automatic logic [RA-1:0] addr(input logic [OW-1:0] o, input logic [IW-1:0] i);
      addr = RA'(o) * RA'(POOL_PAGES) + RA'(i);
   endfunction

   assign cnt_cur  = cnt_ff[cur_ff[OI-1:0]];
   assign idx_nxt  = idx_ff + 1'b1;
   assign nc       = cur_ff - 1'b1;
   assign bud      = XW'(blk_ff) ^ (XW'(1) << cur_ff);
   assign sbud     = XW'(blk_ff) ^ (XW'(1) << nc);
   assign bud_out  = bud >= XW'(pool);
   assign sbud_out = sbud >= XW'(pool);
   assign sz       = UW'(1) << ord_ff;
   assign used_add = (UW'(used_ff) + sz > USED_MAX) ? USED_MAX : UW'(used_ff) + sz;
   assign used_sub = (UW'(used_ff) > sz) ? UW'(used_ff) - sz : '0;

   always_comb begin
      top       = '0;
      top_found = 1'b0;
      for (int o = 0; o <= TOP_ORDER; o++) begin
         if (XW'(pool) >= (XW'(1) << o)) begin
            top       = OI'(o);
            top_found = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   state_in = emit_ff ? ST_DONE : ST_IDLE;
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_INIT:  state_in = ST_INIT;
                  OP_ALLOC: state_in = ST_SEARCH;
                  OP_FREE:  state_in = ST_CHECK;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (cur_ff > OW'(TOP_ORDER)) begin
               state_in = ST_DONE;
            end else if (cnt_cur != '0) begin
               state_in = ST_POP;
            end
         end
         ST_POP:    state_in = ST_SPLIT;
         ST_SPLIT:  state_in = (cur_ff == OW'(ord_ff) || sbud_out) ? ST_DONE : ST_PUSH;
         ST_PUSH:   state_in = alloc_ff ? ST_SPLIT : ST_DONE;
         ST_CHECK:  state_in = (cur_ff >= OW'(TOP_ORDER) || bud_out) ? ST_PUSH : ST_SCAN;
         ST_SCAN:   state_in = (idx_ff == cnt_cur) ? ST_PUSH : ST_CMP;
         ST_CMP:    state_in = (XW'(ram_rd) == bud) ? ST_SHRD : ST_SCAN;
         ST_SHRD:   state_in = (idx_nxt == cnt_cur) ? ST_CHECK : ST_SHWR;
         ST_SHWR:   state_in = ST_SHRD;
         ST_DONE:   state_in = (!rvalid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cur_in     = cur_ff;
      ord_in     = ord_ff;
      blk_in     = blk_ff;
      psh_in     = psh_ff;
      idx_in     = idx_ff;
      alloc_in   = alloc_ff;
      emit_in    = emit_ff;
      used_in    = used_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      blkout_in  = blkout_ff;
      rvalid_in  = rvalid_ff && !rsp_ready;
      rstatus_in = rstatus_ff;
      rblock_in  = rblock_ff;
      rused_in   = rused_ff;
      ram_we     = 1'b0;
      ram_wa     = '0;
      ram_wd     = '0;
      ram_re     = 1'b0;
      ram_ra     = '0;
      unique case (state_ff)
         ST_INIT: begin
            for (int o = 0; o <= TOP_ORDER; o++) begin
               cnt_in[o] = '0;
            end
            used_in = '0;
            emit_in = 1'b0;
            if (top_found) begin
               cnt_in[top] = CW'(1);
               ram_we      = 1'b1;
               ram_wa      = addr(OW'(top), '0);
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               ord_in    = cmd.order;
               cur_in    = OW'(cmd.order);
               blk_in    = IW'(cmd.page);
               alloc_in  = (cmd.op == OP_ALLOC);
               emit_in   = 1'b1;
               blkout_in = '0;
               if (cmd.op == OP_BAD_ORDER) begin
                  status_in = STATUS_BAD_ORD;
               end else if (cmd.op == OP_BAD_ADDR) begin
                  status_in = STATUS_BAD_ADDR;
               end else begin
                  status_in = STATUS_OK;
               end
            end
         end
         ST_SEARCH: begin
            if (cur_ff > OW'(TOP_ORDER)) begin
               status_in = STATUS_NO_MEM;
            end else if (cnt_cur == '0) begin
               cur_in = cur_ff + 1'b1;
            end else begin
               cnt_in[cur_ff[OI-1:0]] = cnt_cur - 1'b1;
               ram_re = 1'b1;
               ram_ra = addr(cur_ff, IW'(cnt_cur - 1'b1));
            end
         end
         ST_POP: blk_in = ram_rd;
         ST_SPLIT: begin
            if (cur_ff == OW'(ord_ff) || sbud_out) begin
               used_in   = used_add[10:0];
               blkout_in = 10'(blk_ff);
            end else begin
               cur_in = nc;
               psh_in = sbud[IW-1:0];
            end
         end
         ST_PUSH: begin
            if (cnt_cur < CW'(POOL_PAGES)) begin
               ram_we                 = 1'b1;
               ram_wa                 = addr(cur_ff, cnt_cur[IW-1:0]);
               ram_wd                 = psh_ff;
               cnt_in[cur_ff[OI-1:0]] = cnt_cur + 1'b1;
            end
            if (!alloc_ff) begin
               used_in = used_sub[10:0];
            end
         end
         ST_CHECK: begin
            psh_in = blk_ff;
            if (cur_ff < OW'(TOP_ORDER) && !bud_out) begin
               idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (idx_ff != cnt_cur) begin
               ram_re = 1'b1;
               ram_ra = addr(cur_ff, idx_ff[IW-1:0]);
            end
         end
         ST_CMP: begin
            if (XW'(ram_rd) != bud) begin
               idx_in = idx_nxt;
            end
         end
         ST_SHRD: begin
            if (idx_nxt == cnt_cur) begin
               cnt_in[cur_ff[OI-1:0]] = cnt_cur - 1'b1;
               if (bud < XW'(blk_ff)) begin
                  blk_in = bud[IW-1:0];
               end
               cur_in = cur_ff + 1'b1;
            end else begin
               ram_re = 1'b1;
               ram_ra = addr(cur_ff, idx_nxt[IW-1:0]);
            end
         end
         ST_SHWR: begin
            ram_we = 1'b1;
            ram_wa = addr(cur_ff, idx_ff[IW-1:0]);
            ram_wd = ram_rd;
            idx_in = idx_nxt;
         end
         ST_DONE: begin
            if (!rvalid_ff || rsp_ready) begin
               rvalid_in  = 1'b1;
               rstatus_in = status_ff;
               rblock_in  = blkout_ff;
               rused_in   = used_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      ord_ff     <= ord_in;
      blk_ff     <= blk_in;
      psh_ff     <= psh_in;
      idx_ff     <= idx_in;
      alloc_ff   <= alloc_in;
      status_ff  <= status_in;
      blkout_ff  <= blkout_in;
      rstatus_ff <= rstatus_in;
      rblock_ff  <= rblock_in;
      rused_ff   <= rused_in;
      if (reset) begin
         state_ff  <= ST_INIT;
         emit_ff   <= 1'b0;
         used_ff   <= '0;
         rvalid_ff <= 1'b0;
         for (int o = 0; o <= TOP_ORDER; o++) begin
            cnt_ff[o] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         emit_ff   <= emit_in;
         used_ff   <= used_in;
         rvalid_ff <= rvalid_in;
         cnt_ff    <= cnt_in;
      end
   end

   bpa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_lists (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rvalid_ff;
   assign rsp_status = rstatus_ff;
   assign rsp_block  = rblock_ff;
   assign rsp_used   = rused_ff;

`ifndef SYNTH
   a_pop_after_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> $past(state_ff) == ST_SEARCH)
      else $error("pop without search");
   a_shift_write_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHWR |-> $past(state_ff) == ST_SHRD && idx_nxt < $past(cnt_cur))
      else $error("shift beyond list");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= cnt_cur)
      else $error("scan past list end");
   a_oom_zero_block: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rstatus_ff != STATUS_OK |-> rblock_ff == '0)
      else $error("failed word carries block");
`endif

endmodule

// ===== design/buddy_page_allocator.sv =====
// Buddy page allocator top level.
//
// Takes one request word (allocate, free or reinitialize) and returns one
// result word per request, in order. Requests are decoded and queued two
// deep; the engine handles one at a time against free lists kept in a single
// RAM of (TOP_ORDER+1)*POOL_PAGES entries. An allocate walks up past empty
// orders, pops a block and pushes the split-off buddies; a free scans the
// list of each merge level for the buddy one entry at a time and shifts
// the later entries down when the buddy is removed; a reinitialize seeds
// the pool anew and a rejected request goes straight to its result word.
// After reset the engine seeds the pool before its first request. The
// pool-size register must be written only while no request is in flight.
`timescale 1ns / 1ps
module buddy_page_allocator import bpa_pkg::*; #(
   parameter int TOP_ORDER  = 10,
   parameter int MIN_ORDER  = 0,
   parameter int POOL_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // req_order[3:0], page_index[14:4], zero pad
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], block[11:2], used[22:12]
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   localparam int PW = $clog2(POOL_PAGES + 1);
   localparam int SW = (PW > 11) ? PW : 11;

   logic [10:0]  total_ff;
   logic [SW-1:0] pool;
   logic         cmd_valid, cmd_ready;
   bpa_cmd_type  cmd;
   logic [1:0]   status;
   logic [9:0]   block;
   logic [10:0]  used;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 11'd1024;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   assign pool = (SW'(total_ff) > SW'(POOL_PAGES)) ? SW'(POOL_PAGES) : SW'(total_ff);

   bpa_front #(
      .TOP_ORDER  (TOP_ORDER),
      .MIN_ORDER  (MIN_ORDER),
      .POOL_PAGES (POOL_PAGES),
      .SW         (SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pool       (pool),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   bpa_back #(
      .TOP_ORDER  (TOP_ORDER),
      .POOL_PAGES (POOL_PAGES),
      .SW         (SW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .pool       (pool),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rsp_block  (block),
      .rsp_used   (used)
   );

   assign rsp_tdata = {1'b0, used, block, status};

endmodule

// ===== tb/sv/bpa_checker.sv =====
// Result checker for the buddy page allocator: predicts each word and compares.
`timescale 1ns / 1ps
module bpa_checker import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);

   localparam int TOP_ORDER = 10;
   localparam int LOW_ORDER = 0;
   localparam int POOL_MAX  = 1024;
   localparam int USED_SAT  = 2047;

   typedef struct {
      logic [1:0]  status;
      logic [9:0]  block;
      logic [10:0] used;
   } alloc_result_type;

   logic [9:0]       spare_lists [TOP_ORDER+1][POOL_MAX];
   int               list_len [TOP_ORDER+1];
   int               used_count;
   int               pool_cfg;
   alloc_result_type expected_results[$];

   function automatic int pool_limit();
      return (pool_cfg > POOL_MAX) ? POOL_MAX : pool_cfg;
   endfunction

   function automatic void push_free(int ord, int idx);
      if (list_len[ord] < POOL_MAX) begin
         spare_lists[ord][list_len[ord]] = idx[9:0];
         list_len[ord]++;
      end
   endfunction

   function automatic bit take_free(int ord, int idx);
      for (int i = 0; i < list_len[ord]; i++) begin
         if (spare_lists[ord][i] == idx[9:0]) begin
            for (int j = i; j < list_len[ord] - 1; j++)
               spare_lists[ord][j] = spare_lists[ord][j+1];
            list_len[ord]--;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void reinit_pool();
      int pages;
      pages = pool_limit();
      for (int o = 0; o <= TOP_ORDER; o++)
         list_len[o] = 0;
      used_count = 0;
      for (int o = TOP_ORDER; o >= 0; o--) begin
         if (pages >= (1 << o)) begin
            push_free(o, 0);
            break;
         end
      end
   endfunction

   function automatic alloc_result_type predict(logic [1:0] func, int ord, int page);
      alloc_result_type r;
      int cur, blk, bud, m;
      r.status = STATUS_OK;
      blk = 0;
      if (func == FUNC_INIT) begin
         reinit_pool();
      end else if (func == FUNC_ALLOC || func == FUNC_FREE) begin
         if (ord < LOW_ORDER || ord > TOP_ORDER) begin
            r.status = STATUS_BAD_ORD;
         end else if (func == FUNC_ALLOC) begin
            cur = ord;
            while (cur <= TOP_ORDER && list_len[cur] == 0)
               cur++;
            if (cur > TOP_ORDER) begin
               r.status = STATUS_NO_MEM;
            end else begin
               list_len[cur]--;
               blk = spare_lists[cur][list_len[cur]];
               while (cur > ord) begin
                  cur--;
                  bud = blk ^ (1 << cur);
                  if (bud >= pool_limit())
                     break;
                  push_free(cur, bud);
               end
               used_count += 1 << ord;
               if (used_count > USED_SAT)
                  used_count = USED_SAT;
            end
         end else begin
            if (page >= pool_limit()) begin
               r.status = STATUS_BAD_ADDR;
            end else begin
               cur = ord;
               m = page;
               while (cur < TOP_ORDER) begin
                  bud = m ^ (1 << cur);
                  if (bud >= pool_limit())
                     break;
                  if (!take_free(cur, bud))
                     break;
                  if (bud < m)
                     m = bud;
                  cur++;
               end
               push_free(cur, m);
               used_count = (used_count > (1 << ord)) ? used_count - (1 << ord) : 0;
            end
         end
      end
      r.block = blk[9:0];
      r.used = used_count[10:0];
      return r;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         pool_cfg = 1024;
         reinit_pool();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.block = rsp_tdata[11:2];
            got.used = rsp_tdata[22:12];
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: status %0d block %0d used %0d",
                           got.status, got.block, got.used);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.block !== want.block ||
                   got.used !== want.used) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d block %0d used %0d, got %0d %0d %0d",
                              want.status, want.block, want.used,
                              got.status, got.block, got.used);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict(req_tuser, int'(req_tdata[3:0]),
                                               int'(req_tdata[14:4])));
         if (csr_wr_en)
            pool_cfg = int'(csr_wr_data);
      end
   end

endmodule

// ===== tb/sv/tb_buddy_page_allocator.sv =====
// Testbench top for the buddy page allocator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_buddy_page_allocator import bpa_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct {
      int page;
      int ord;
   } live_block_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en = 0;
   logic [10:0] csr_wr_data = '0;
   int          fail_count;
   int          pending;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          idle_cycles = 0;
   int          pool_now = 1024;
   live_block_type live_blocks[$];
   logic [1:0]  sent_func[$];
   int          sent_order[$];

   buddy_page_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bpa_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // track live blocks so frees hit real allocations
   always @(posedge clock) begin
      logic [1:0] f;
      int o;
      if (!reset && rsp_tvalid && rsp_tready && sent_func.size() > 0) begin
         f = sent_func.pop_front();
         o = sent_order.pop_front();
         if (f == FUNC_INIT)
            live_blocks.delete();
         else if (f == FUNC_ALLOC && rsp_tdata[1:0] == STATUS_OK)
            live_blocks.push_back('{int'(rsp_tdata[11:2]), o});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[buddy_page_allocator] ERROR");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] func, logic [3:0] ord, logic [10:0] page);
      int gap;
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= func;
      req_tdata <= {1'b0, page, ord};
      @(posedge clock iff req_tready);
      sent_func.push_back(func);
      sent_order.push_back(int'(ord));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_pool(int pages);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= pages[10:0];
      @(posedge clock);
      csr_wr_en <= 0;
      pool_now = (pages > 1024) ? 1024 : pages;
      send_word(FUNC_INIT, 4'd0, 11'd0);
   endtask

   task automatic random_word();
      int pick;
      int k;
      int o;
      live_block_type b;
      pick = $urandom_range(99);
      if (pick < 45) begin
         o = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(15);
         send_word(FUNC_ALLOC, o[3:0], 11'($urandom));
      end else if (pick < 80 && live_blocks.size() > 0) begin
         k = $urandom_range(live_blocks.size() - 1);
         b = live_blocks[k];
         live_blocks.delete(k);
         send_word(FUNC_FREE, b.ord[3:0], b.page[10:0]);
      end else if (pick < 90) begin
         o = $urandom_range(10);
         k = (pool_now > 0) ? ($urandom_range(pool_now - 1) & ~((1 << o) - 1)) : 0;
         send_word(FUNC_FREE, o[3:0], k[10:0]);
      end else if (pick < 97) begin
         send_word(2'($urandom), 4'($urandom), 11'($urandom));
      end else begin
         send_word(FUNC_INIT, 4'($urandom), 11'($urandom));
      end
   endtask

   initial begin
      int pools[7] = '{1024, 1, 2047, 37, 0, 600, 1024};
      int stalls[4] = '{0, 0, 64, 31};
      int gaps[4] = '{0, 64, 0, 31};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: splits, merges, extremes and bad inputs
      send_word(FUNC_ALLOC, 4'd0, 11'd0);
      send_word(FUNC_ALLOC, 4'd10, 11'd0);
      send_word(FUNC_ALLOC, 4'd3, 11'h7FF);
      send_word(FUNC_FREE, 4'd0, 11'd0);
      send_word(FUNC_FREE, 4'd3, 11'd8);
      send_word(FUNC_FREE, 4'd0, 11'd0);
      send_word(FUNC_ALLOC, 4'd11, 11'd0);
      send_word(FUNC_FREE, 4'd15, 11'd0);
      send_word(FUNC_FREE, 4'd0, 11'd1024);
      send_word(FUNC_FREE, 4'd0, 11'h7FF);
      send_word(FUNC_ALLOC, 4'd10, 11'd0);
      send_word(FUNC_ALLOC, 4'd10, 11'd0);
      send_word(FUNC_FREE, 4'd10, 11'd0);
      send_word(FUNC_FREE, 4'd10, 11'd0);
      send_word(FUNC_FREE, 4'd10, 11'd0);
      send_word(2'd3, 4'hF, 11'h7FF);
      send_word(FUNC_INIT, 4'd0, 11'd0);
      send_word(FUNC_FREE, 4'd0, 11'd0);
      send_word(FUNC_FREE, 4'd0, 11'h3FF);
      write_pool(37);
      send_word(FUNC_ALLOC, 4'd2, 11'd0);
      send_word(FUNC_ALLOC, 4'd2, 11'd0);
      send_word(FUNC_FREE, 4'd0, 11'd36);
      send_word(FUNC_FREE, 4'd0, 11'd37);

      for (int p = 0; p < 7; p++) begin
         write_pool(pools[p]);
         for (int i = 0; i < 60; i++) begin
            send_idle = gaps[(i / 15) % 4];
            recv_stall = stalls[(i / 15) % 4];
            random_word();
            if (p == 3 && i == 30)
               drain();
         end
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
      if (fail_count == 0) begin
         $display("[buddy_page_allocator] OK");
      end else begin
         $display("[buddy_page_allocator] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_front.sv
design/bpa_back.sv
design/buddy_page_allocator.sv
tb/sv/bpa_checker.sv
tb/sv/tb_buddy_page_allocator.sv
